// ===== design/lsf_pkg.sv =====
// Shared types and constants for the line segment filter.
`default_nettype none
package lsf_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VERTICAL_LIMIT = 3'd0,
    REG_VANISH_X       = 3'd1,
    REG_VANISH_Y       = 3'd2,
    REG_MAX_ANGLE_DEV  = 3'd3,
    REG_IMAGE_WIDTH    = 3'd4
  } cfg_reg_e;

  localparam logic [15:0] PolyC3     = 16'd3047;
  localparam logic [15:0] PolyC2     = 16'd10441;
  localparam logic [15:0] PolyC1     = 16'd21471;
  localparam logic [17:0] HalfPiQ16  = 18'd102944;
  localparam logic [17:0] PiQ16      = 18'd205887;
  localparam logic [21:0] Rad2DegQ16 = 22'd3754936;

  typedef struct packed {
    logic [10:0] vertical_limit;
    logic [10:0] vanish_x;
    logic [10:0] vanish_y;
    logic [15:0] max_angle_dev;
    logic [11:0] image_width;
  } cfg_t;

  // Per-operand arctangent control carried along the pipeline.
  typedef struct packed {
    logic y_zero;
    logic x_zero;
    logic y_neg;
    logic x_neg;
    logic swap;
  } atan_ctl_t;

endpackage
`default_nettype wire

// ===== design/lsf_stream_if.sv =====
// Valid/ready stream interface with a generic payload.
`default_nettype none
interface lsf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/lsf_divider.sv =====
// Pipelined restoring divider: quotient = (num << 16) / den, one bit per stage.
`default_nettype none
module lsf_divider #(
  parameter int unsigned CoordBits = 11,
  parameter type         tag_t     = logic
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [CoordBits-1:0] num_i,
  input  wire logic [CoordBits-1:0] den_i,
  input  tag_t                      tag_i,
  output logic                      valid_o,
  output logic [16:0]               quot_o,
  output tag_t                      tag_o
);
  // Numerator min <= den so quotient fits 17 bits (value 65536 when equal).
  localparam int unsigned Steps = 17;
  localparam int unsigned RemW  = CoordBits + 1;
  localparam int unsigned NumW  = CoordBits + 16;

  logic [RemW-1:0]      rem_q  [Steps+1];
  logic [NumW-1:0]      num_q  [Steps+1];
  logic [CoordBits-1:0] den_q  [Steps+1];
  logic [16:0]          quo_q  [Steps+1];
  tag_t                 tag_q  [Steps+1];
  logic                 vld_q  [Steps+1];

  // Upper numerator bits give zero quotient bits; start with them as the remainder.
  assign rem_q[0] = {2'b0, num_i[CoordBits-1:1]};
  assign num_q[0] = {num_i, 16'd0};
  assign den_q[0] = den_i;
  assign quo_q[0] = '0;
  assign tag_q[0] = tag_i;
  assign vld_q[0] = valid_i;

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [RemW-1:0] trial;
    logic [RemW:0]   diff;
    assign trial = {rem_q[i][RemW-2:0], num_q[i][Steps-1-i]};
    assign diff  = {1'b0, trial} - {2'b0, den_q[i]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!diff[RemW]) begin
          rem_q[i+1] <= diff[RemW-1:0];
        end else begin
          rem_q[i+1] <= trial;
        end
        quo_q[i+1] <= {quo_q[i][15:0], ~diff[RemW]};
        num_q[i+1] <= num_q[i];
        den_q[i+1] <= den_q[i];
        tag_q[i+1] <= tag_q[i];
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign quot_o  = quo_q[Steps];
  assign tag_o   = tag_q[Steps];
endmodule
`default_nettype wire

// ===== design/lsf_atan_poly.sv =====
// Pipelined polynomial arctangent: Q16 ratio to degrees with octant fix-up.
`default_nettype none
module lsf_atan_poly
  import lsf_pkg::*;
#(
  parameter int unsigned AngleFracBits = 8,
  parameter type         tag_t         = logic
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   en_i,
  input  wire logic   valid_i,
  input  wire logic [16:0] ratio_i,
  input  atan_ctl_t   ctl_i,
  input  tag_t        tag_i,
  output logic        valid_o,
  output logic [AngleFracBits+7:0] deg_o,
  output tag_t        tag_o
);
  localparam int unsigned DegW = AngleFracBits + 8;
  localparam logic [DegW-1:0] Deg180 = DegW'(180 << AngleFracBits);
  localparam logic [DegW-1:0] Deg90  = DegW'(90 << AngleFracBits);
  localparam logic [40:0] RoundC = 41'(64'd1 << (31 - AngleFracBits));

  logic [7:0] vld_q;
  logic [16:0] a_q [8];
  atan_ctl_t   c_q [8];
  tag_t        t_q [8];
  logic [16:0] s_q [3];
  logic [15:0] p1_q;
  logic [15:0] q_q;
  logic [15:0] qs_q;
  logic [17:0] r_q;
  logic [40:0] prod_q;

  // stage 1: s = a*a >> 16
  logic [33:0] sq;
  assign sq = a_q[0] * a_q[0];
  // stage 2: p1 = C2 - C3*s>>16
  logic [32:0] c3s;
  assign c3s = PolyC3 * s_q[0];
  // stage 3: q = C1 - (p1*s>>16)
  logic [32:0] p1s;
  assign p1s = p1_q * s_q[1];
  // stage 4: qs = q*s >> 16
  logic [32:0] qsm;
  assign qsm = q_q * s_q[2];
  // stage 5: r = a - qs*a>>16, octant fold
  logic [32:0] qsa;
  logic [17:0] r0, r1, r2;
  assign qsa = qs_q * a_q[4];
  assign r0  = {1'b0, a_q[4]} - {2'b0, qsa[31:16]};
  assign r1  = c_q[4].swap ? (HalfPiQ16 - r0) : r0;
  assign r2  = c_q[4].x_neg ? (PiQ16 - r1) : r1;
  // stage 6: scale to degrees
  logic [40:0] pr;
  assign pr = 41'(r_q) * 41'(Rad2DegQ16);
  // stage 7: round, saturate, sign fold; stage 8 registers the angle
  logic [40:0] rounded;
  logic [DegW-1:0] dsat, dfin;
  assign rounded = (prod_q + RoundC) >> (32 - AngleFracBits);
  assign dsat = (rounded > 41'(Deg180)) ? Deg180 : rounded[DegW-1:0];
  always_comb begin
    if (c_q[6].y_zero) dfin = '0;
    else if (c_q[6].x_zero) dfin = Deg90;
    else if (c_q[6].y_neg) dfin = Deg180 - dsat;
    else dfin = dsat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0] <= ratio_i;
      c_q[0] <= ctl_i;
      t_q[0] <= tag_i;
      for (int i = 1; i < 8; i++) begin
        a_q[i] <= a_q[i-1];
        c_q[i] <= c_q[i-1];
        t_q[i] <= t_q[i-1];
      end
      s_q[0] <= sq[32:16];
      s_q[1] <= s_q[0];
      s_q[2] <= s_q[1];
      p1_q   <= PolyC2 - c3s[31:16];
      q_q    <= PolyC1 - p1s[31:16];
      qs_q   <= qsm[31:16];
      r_q    <= r2;
      prod_q <= pr;
      deg_o  <= dfin;
    end
  end

  assign valid_o = vld_q[7];
  assign tag_o   = t_q[7];
endmodule
`default_nettype wire

// ===== design/line_segment_filter_unit.sv =====
// Top level of the line segment filter pipeline.
// Accepts one segment per cycle unless the output stalls, and returns one result per segment,
// in order, through 28 register stages (2 front-end stages, a 17-stage bit-per-stage divider
// for the min/max ratio, an 8-stage polynomial arctangent, and a compare/output stage). Both
// arctangents (segment and vanishing direction) run side by side. A stall on the output
// freezes the whole pipeline: input ready drops only while a result waits in the output
// register and the receiver is not ready.
`default_nettype none
module line_segment_filter_unit
  import lsf_pkg::*;
#(
  parameter int unsigned COORD_BITS      = 11,
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  lsf_stream_if.sink               in_if,
  lsf_stream_if.source             out_if
);
  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned DegW = ANGLE_FRAC_BITS + 8;

  typedef struct packed {
    logic [CB-1:0] mid_x;
    logic [CB-1:0] mid_y;
    logic          row_ok;
  } side_t;

  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vertical_limit <= 11'd280;
      cfg_q.vanish_x       <= 11'd400;
      cfg_q.vanish_y       <= 11'd260;
      cfg_q.max_angle_dev  <= 16'd5120;
      cfg_q.image_width    <= 12'd800;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VERTICAL_LIMIT: cfg_q.vertical_limit <= cfg_data_i[10:0];
        REG_VANISH_X:       cfg_q.vanish_x       <= cfg_data_i[10:0];
        REG_VANISH_Y:       cfg_q.vanish_y       <= cfg_data_i[10:0];
        REG_MAX_ANGLE_DEV:  cfg_q.max_angle_dev  <= cfg_data_i;
        REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  // Stage A: midpoint and signed differences.
  logic          a_vld_q;
  logic [CB-1:0] a_mx_q, a_my_q;
  logic [CB:0]   a_dx_q, a_dy_q;
  logic [CB:0]   sum_x, sum_y;
  assign sum_x = {1'b0, CB'(in_if.data.start_x)} + {1'b0, CB'(in_if.data.end_x)};
  assign sum_y = {1'b0, CB'(in_if.data.start_y)} + {1'b0, CB'(in_if.data.end_y)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= in_if.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mx_q <= sum_x[CB:1];
      a_my_q <= sum_y[CB:1];
      a_dx_q <= {1'b0, CB'(in_if.data.end_x)} - {1'b0, CB'(in_if.data.start_x)};
      a_dy_q <= {1'b0, CB'(in_if.data.end_y)} - {1'b0, CB'(in_if.data.start_y)};
    end
  end

  // Stage B: abs, min/max, control for both arctangents.
  logic [CB:0] vdx, vdy;
  assign vdx = {1'b0, CB'(cfg_q.vanish_x)} - {1'b0, a_mx_q};
  assign vdy = {1'b0, CB'(cfg_q.vanish_y)} - {1'b0, a_my_q};

  function automatic logic [CB-1:0] abs_f(input logic [CB:0] v);
    logic [CB:0] n;
    n = v[CB] ? (~v + 1'b1) : v;
    return n[CB-1:0];
  endfunction

  logic          b_vld_q;
  logic [CB-1:0] b_mn_q [2];
  logic [CB-1:0] b_mx_q [2];
  atan_ctl_t     b_ctl_q [2];
  side_t         b_side_q;
  logic [CB:0]   dxs [2];
  logic [CB:0]   dys [2];
  assign dxs[0] = a_dx_q;
  assign dys[0] = a_dy_q;
  assign dxs[1] = vdx;
  assign dys[1] = vdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (en) b_vld_q <= a_vld_q;
  end
  for (genvar k = 0; k < 2; k++) begin : g_pre
    logic [CB-1:0] ax, ay;
    assign ax = abs_f(dxs[k]);
    assign ay = abs_f(dys[k]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        b_mn_q[k]         <= (ay < ax) ? ay : ax;
        b_mx_q[k]         <= (ay < ax) ? ax : ay;
        b_ctl_q[k].y_zero <= (dys[k] == '0);
        b_ctl_q[k].x_zero <= (dxs[k] == '0);
        b_ctl_q[k].y_neg  <= dys[k][CB];
        b_ctl_q[k].x_neg  <= dxs[k][CB];
        b_ctl_q[k].swap   <= (ay > ax);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_side_q.mid_x  <= a_mx_q;
      b_side_q.mid_y  <= a_my_q;
      b_side_q.row_ok <= (16'(a_my_q) >= 16'(cfg_q.vertical_limit));
    end
  end

  // Divider and arctangent lanes; both lanes carry the side data as tag, lane 0's copy is used.
  logic          dv_vld [2];
  logic [16:0]   dv_q   [2];
  atan_ctl_t     dv_ctl [2];
  side_t         dv_side;
  logic          at_vld [2];
  logic [DegW-1:0] at_deg [2];
  side_t         at_side;
  logic [DegW-1:0] seg_deg, vp_deg;

  typedef struct packed {
    atan_ctl_t ctl;
    side_t     side;
  } tag_t;
  tag_t dv_tag [2];
  tag_t at_tag [2];

  for (genvar k = 0; k < 2; k++) begin : g_lane
    tag_t tin;
    assign tin.ctl  = b_ctl_q[k];
    assign tin.side = b_side_q;
    // Zero max only occurs with y_zero, result is then forced anyway.
    logic [CB-1:0] den;
    assign den = (b_mx_q[k] == '0) ? CB'(1) : b_mx_q[k];
    lsf_divider #(.CoordBits(CB), .tag_t(tag_t)) u_div (
      .clk_i, .rst_ni, .en_i(en), .valid_i(b_vld_q),
      .num_i(b_mn_q[k]), .den_i(den), .tag_i(tin),
      .valid_o(dv_vld[k]), .quot_o(dv_q[k]), .tag_o(dv_tag[k])
    );
    lsf_atan_poly #(.AngleFracBits(ANGLE_FRAC_BITS), .tag_t(tag_t)) u_atan (
      .clk_i, .rst_ni, .en_i(en), .valid_i(dv_vld[k]),
      .ratio_i(dv_q[k]), .ctl_i(dv_tag[k].ctl), .tag_i(dv_tag[k]),
      .valid_o(at_vld[k]), .deg_o(at_deg[k]), .tag_o(at_tag[k])
    );
  end
  assign dv_ctl[0]  = dv_tag[0].ctl;
  assign dv_ctl[1]  = dv_tag[1].ctl;
  assign dv_side    = dv_tag[0].side;
  assign at_side    = at_tag[0].side;
  assign seg_deg    = at_deg[0];
  assign vp_deg     = at_deg[1];

  // Final stage: compare and classify.
  logic [DegW-1:0] diff;
  logic            ok;
  logic [CB+2:0]   cx5;
  logic [13:0]     w3;
  logic [13:0]     w2;
  assign diff = (seg_deg > vp_deg) ? (seg_deg - vp_deg) : (vp_deg - seg_deg);
  assign ok   = at_side.row_ok && ({16'd0, diff} <= {16'd0, cfg_q.max_angle_dev});
  assign cx5  = ({3'd0, at_side.mid_x} << 2) + {3'd0, at_side.mid_x};
  assign w3   = ({2'd0, cfg_q.image_width} << 1) + {2'd0, cfg_q.image_width};
  assign w2   = {1'b0, cfg_q.image_width, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= at_vld[0];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_if.data.accepted  <= ok;
      out_if.data.seg_angle <= 16'(seg_deg);
      out_if.data.mid_x     <= 11'(at_side.mid_x);
      out_if.data.mid_y     <= 11'(at_side.mid_y);
      out_if.data.is_left   <= ok && (32'(cx5) < 32'(w3));
      out_if.data.is_right  <= ok && (32'(cx5) > 32'(w2));
    end
  end
  assign out_if.valid = out_valid_q;

  // Lanes stay in lockstep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) at_vld[0] == at_vld[1])
    else $error("arctangent lanes out of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni) dv_vld[0] == dv_vld[1])
    else $error("divider lanes out of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.data.accepted |-> !out_if.data.is_left && !out_if.data.is_right)
    else $error("rejected segment marked");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld[0] && !dv_ctl[0].y_zero |-> dv_q[0] <= 17'd65536)
    else $error("ratio above one");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result dropped under stall");
  // dv_side is used for visibility of the lane tag alignment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld[0] |-> dv_side == dv_tag[1].side)
    else $error("side data misaligned");
endmodule
`default_nettype wire
